// ----- design/pdt_pkg.sv -----
// Shared types, codes and the comfort classifier for the pressure dispersion tracker.
package pdt_pkg;

  localparam int KIND_W      = 2;
  localparam int RAW_W       = 15;
  localparam int TENTHS_W    = 16;
  localparam int COMFORT_W   = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Millibar x16 to tenths mmHg, scaled by 2^32.
  localparam int CONV_K_W = 31;
  localparam logic [CONV_K_W-1:0] CONV_K = 31'd2013437062;
  localparam int PROD_W = RAW_W + CONV_K_W;

  localparam logic [KIND_W-1:0] KIND_READING = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FAIL    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WARNING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL = 2'd2;

  localparam logic [COMFORT_W-1:0] COMFORT_UNKNOWN  = 3'd0;
  localparam logic [COMFORT_W-1:0] COMFORT_NORMAL   = 3'd1;
  localparam logic [COMFORT_W-1:0] COMFORT_WARNING  = 3'd2;
  localparam logic [COMFORT_W-1:0] COMFORT_HIGH     = 3'd3;
  localparam logic [COMFORT_W-1:0] COMFORT_CRITICAL = 3'd4;

  localparam logic [TENTHS_W-1:0] WARNING_RST  = 16'd60;
  localparam logic [TENTHS_W-1:0] HIGH_RST     = 16'd75;
  localparam logic [TENTHS_W-1:0] CRITICAL_RST = 16'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_UPD,
    ST_SCAN,
    ST_CLASS,
    ST_EMIT
  } pdt_state_t;

  // The tests run in a fixed order, so thresholds need not be ascending.
  function automatic logic [COMFORT_W-1:0] classify(
    input logic [TENTHS_W-1:0] spread,
    input logic [TENTHS_W-1:0] warn_th,
    input logic [TENTHS_W-1:0] high_th,
    input logic [TENTHS_W-1:0] crit_th
  );
    logic [COMFORT_W-1:0] level;
    if (spread < warn_th) begin
      level = COMFORT_NORMAL;
    end else if (spread < high_th) begin
      level = COMFORT_WARNING;
    end else if (spread < crit_th) begin
      level = COMFORT_HIGH;
    end else begin
      level = COMFORT_CRITICAL;
    end
    return level;
  endfunction

endpackage

// ----- design/pressure_dispersion_tracker_core.sv -----
// Top level of the pressure dispersion tracker: conversion, hour ring and comfort sequencer.
//
//  Channel | Ports                      | Contents
//  --------+----------------------------+----------------------------------------------
//  in      | in_tvalid/tready/tdata/tuser| tdata: raw_millibar; tuser: kind
//  out     | out_tvalid/tready/tdata    | pressure, spread, comfort level, changed flag
//  cfg     | cfg_valid/ready/index/data | threshold writes, always ready
//
// A reading's result is registered after one multiply, one update of the open hour, one
// ring read per older kept hour and one more to fold the last of them, then spread,
// classification and the output register. A failure's result goes straight to the output
// step and is registered there; a tick only advances the ring and the input is ready at once.
// The block is not ready while an item is in work and is ready again in the cycle after
// its result is registered. A result waits in the output register, and the next item is
// accepted while it waits; if a result is still waiting when the next one is due, the
// sequencer holds in its last step until the receiver takes the waiting result.
// Reset clears the ring by valid bits at once, so no clearing pass is needed.
module pressure_dispersion_tracker_core #(
  parameter int HISTORY_HOURS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pdt_pkg::IN_TDATA_W-1:0]    in_tdata,   // [14:0] raw_millibar
  input  logic [pdt_pkg::IN_TUSER_W-1:0]    in_tuser,   // [1:0] kind
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] pressure_tenths, [31:16] spread_tenths, [34:32] comfort_level,
  // [35] comfort_changed
  output logic [pdt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pdt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pdt_pkg::*;

  localparam int IDX_W = $clog2(HISTORY_HOURS);
  localparam int CNT_W = $clog2(HISTORY_HOURS + 1);
  localparam int ENT_W = 2 * TENTHS_W;
  localparam int SUM_W = PROD_W + 2;

  function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == '0) begin
      res = IDX_W'(HISTORY_HOURS - 1);
    end else begin
      res = idx - 1'b1;
    end
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(HISTORY_HOURS - 1)) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

  pdt_state_t state_r, state_nxt;

  logic [TENTHS_W-1:0]      warn_th_r, high_th_r, crit_th_r;
  logic [RAW_W-1:0]         raw_r, raw_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic [TENTHS_W-1:0]      p_r, p_nxt;
  logic [TENTHS_W-1:0]      lo_r, lo_nxt;
  logic [TENTHS_W-1:0]      hi_r, hi_nxt;
  logic [TENTHS_W-1:0]      spread_r, spread_nxt;
  logic                     fail_r, fail_nxt;
  logic [IDX_W-1:0]         newest_r, newest_nxt;
  logic [IDX_W-1:0]         scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]         kept_r, kept_nxt;
  logic [CNT_W-1:0]         k_r, k_nxt;
  logic                     pend_r, pend_nxt;
  logic [HISTORY_HOURS-1:0] valid_r, valid_nxt;
  logic                     rd_ok_r;
  logic [COMFORT_W-1:0]     last_comfort_r, last_comfort_nxt;
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]   out_tdata_r, out_tdata_nxt;

  logic                     in_fire;
  logic [KIND_W-1:0]        in_kind;
  logic                     out_free;
  logic                     scan_issue;
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_raddr;
  logic [ENT_W-1:0]         ram_wdata;
  logic [ENT_W-1:0]         ram_rdata;
  logic [ENT_W-1:0]         entry;
  logic [SUM_W-1:0]         round_sum;
  logic [TENTHS_W-1:0]      conv_p;
  logic [TENTHS_W-1:0]      new_min, new_max;
  logic [TENTHS_W-1:0]      old_min, old_max;
  logic [COMFORT_W-1:0]     comfort;

  assign in_kind    = in_tuser[KIND_W-1:0];
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_ready  = 1'b1;
  assign scan_issue = (k_r < kept_r);

  pdt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (HISTORY_HOURS)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (newest_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // An entry whose valid bit is clear reads as empty.
  assign entry     = rd_ok_r ? ram_rdata : '0;
  assign round_sum = {2'b00, prod_r} + (SUM_W'(1) << 31);
  assign conv_p    = round_sum[SUM_W-1 -: TENTHS_W];
  assign old_min   = entry[TENTHS_W-1:0];
  assign old_max   = entry[ENT_W-1:TENTHS_W];
  assign new_min   = (old_min != '0 && conv_p >= old_min) ? old_min : conv_p;
  assign new_max   = (old_max != '0 && conv_p <= old_max) ? old_max : conv_p;
  assign ram_we    = (state_r == ST_UPD);
  assign ram_wdata = {new_max, new_min};
  assign ram_raddr = (state_r == ST_SCAN) ? scan_idx_r : newest_r;
  assign comfort   = fail_r ? COMFORT_UNKNOWN
                            : classify(spread_r, warn_th_r, high_th_r, crit_th_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_kind == KIND_READING) begin
            state_nxt = ST_CONV;
          end else if (in_kind == KIND_FAIL) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_CONV:  state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (!scan_issue && !pend_r) begin
          state_nxt = ST_CLASS;
        end
      end
      ST_CLASS: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    raw_nxt          = raw_r;
    prod_nxt         = prod_r;
    p_nxt            = p_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    spread_nxt       = spread_r;
    fail_nxt         = fail_r;
    newest_nxt       = newest_r;
    scan_idx_nxt     = scan_idx_r;
    kept_nxt         = kept_r;
    k_nxt            = k_r;
    pend_nxt         = pend_r;
    valid_nxt        = valid_r;
    last_comfort_nxt = last_comfort_r;
    out_tvalid_nxt   = out_tvalid_r && !out_tready;
    out_tdata_nxt    = out_tdata_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          raw_nxt  = in_tdata[RAW_W-1:0];
          fail_nxt = (in_kind == KIND_FAIL);
          p_nxt    = '0;
          spread_nxt = '0;
          if (in_kind == KIND_TICK) begin
            newest_nxt = slot_inc(newest_r);
            valid_nxt[slot_inc(newest_r)] = 1'b0;
            if (kept_r < CNT_W'(HISTORY_HOURS)) begin
              kept_nxt = kept_r + 1'b1;
            end
          end
        end
      end
      ST_CONV: begin
        prod_nxt = PROD_W'(raw_r) * PROD_W'(CONV_K);
      end
      ST_UPD: begin
        p_nxt               = conv_p;
        lo_nxt              = new_min;
        hi_nxt              = new_max;
        valid_nxt[newest_r] = 1'b1;
        scan_idx_nxt        = slot_dec(newest_r);
        k_nxt               = CNT_W'(1);
        pend_nxt            = 1'b0;
      end
      ST_SCAN: begin
        // Issue the read of the next older hour while folding the one read last cycle.
        if (scan_issue) begin
          scan_idx_nxt = slot_dec(scan_idx_r);
          k_nxt        = k_r + 1'b1;
        end
        pend_nxt = scan_issue;
        if (pend_r) begin
          if (old_min != '0 && old_min < lo_r) begin
            lo_nxt = old_min;
          end
          if (old_max != '0 && old_max > hi_r) begin
            hi_nxt = old_max;
          end
        end
      end
      ST_CLASS: begin
        spread_nxt = hi_r - lo_r;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_tvalid_nxt   = 1'b1;
          out_tdata_nxt    = {4'b0000, (comfort != last_comfort_r), comfort, spread_r, p_r};
          last_comfort_nxt = comfort;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      warn_th_r      <= WARNING_RST;
      high_th_r      <= HIGH_RST;
      crit_th_r      <= CRITICAL_RST;
      newest_r       <= '0;
      kept_r         <= CNT_W'(1);
      valid_r        <= '0;
      last_comfort_r <= COMFORT_UNKNOWN;
      out_tvalid_r   <= 1'b0;
      pend_r         <= 1'b0;
      k_r            <= '0;
    end else begin
      state_r        <= state_nxt;
      newest_r       <= newest_nxt;
      kept_r         <= kept_nxt;
      valid_r        <= valid_nxt;
      last_comfort_r <= last_comfort_nxt;
      out_tvalid_r   <= out_tvalid_nxt;
      pend_r         <= pend_nxt;
      k_r            <= k_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WARNING:  warn_th_r <= cfg_data;
          REG_HIGH:     high_th_r <= cfg_data;
          REG_CRITICAL: crit_th_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    raw_r      <= raw_nxt;
    prod_r     <= prod_nxt;
    p_r        <= p_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    spread_r   <= spread_nxt;
    fail_r     <= fail_nxt;
    scan_idx_r <= scan_idx_nxt;
    rd_ok_r    <= valid_r[ram_raddr];
    out_tdata_r <= out_tdata_nxt;
  end

`ifndef SYNTHESIS
  a_kept_range: assert property (@(posedge clk) disable iff (!rst_n)
    (kept_r != '0) && (kept_r <= CNT_W'(HISTORY_HOURS)))
    else $error("hour count out of range");

  a_tick_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_kind == KIND_TICK) |=> !valid_r[newest_r])
    else $error("new hour not empty after tick");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[34:32] == COMFORT_UNKNOWN) |->
      (out_tdata_r[31:0] == '0))
    else $error("unknown comfort carries a value");

  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !ram_we)
    else $error("ring written during scan");
`endif

endmodule

// ----- design/pdt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module pdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- bench/tb_pressure_dispersion_tracker_core.sv -----
// Self-checking bench for the pressure dispersion tracker core with a modelled hour ring.
module tb_pressure_dispersion_tracker_core;
  timeunit 1ns;
  timeprecision 1ps;
  import pdt_pkg::*;

  localparam int RING_HOURS      = 4;
  localparam int SETTLE_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PRESSURE_HOLD   = 300;
  localparam int ITEMS_PER_PHASE = 315;
  localparam int MAX_PRINTED     = 40;

  localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

  localparam logic [TENTHS_W-1:0] WARN_DEFAULT = 16'd60;
  localparam logic [TENTHS_W-1:0] HIGH_DEFAULT = 16'd75;
  localparam logic [TENTHS_W-1:0] CRIT_DEFAULT = 16'd100;
  localparam logic [TENTHS_W-1:0] TH_MAX       = 16'hFFFF;

  // Millibar x16 to tenths of mmHg, as a fraction of 2^32.
  localparam logic [63:0] MMHG_TENTHS_K = 64'd2013437062;
  localparam logic [63:0] ROUND_HALF    = 64'h8000_0000;

  typedef enum int {
    FLOW_STEADY,
    FLOW_SRC_GAPS,
    FLOW_SINK_STALLS,
    FLOW_BOTH
  } flow_mode_t;

  typedef struct {
    logic [TENTHS_W-1:0]  pressure;
    logic [TENTHS_W-1:0]  spread;
    logic [COMFORT_W-1:0] level;
    logic                 changed;
  } reading_result_t;

  class comfort_scoreboard;
    logic [TENTHS_W-1:0]  warn_th;
    logic [TENTHS_W-1:0]  high_th;
    logic [TENTHS_W-1:0]  crit_th;
    logic [TENTHS_W-1:0]  hour_lo[RING_HOURS];
    logic [TENTHS_W-1:0]  hour_hi[RING_HOURS];
    int                   open_slot;
    int                   hours_held;
    logic [COMFORT_W-1:0] prev_level;
    reading_result_t      expected_results[$];
    int                   mismatches;
    int                   checked;
    int                   readings;
    int                   ticks;
    int                   failures;

    function new();
      warn_th = WARN_DEFAULT;
      high_th = HIGH_DEFAULT;
      crit_th = CRIT_DEFAULT;
      foreach (hour_lo[i]) begin
        hour_lo[i] = '0;
        hour_hi[i] = '0;
      end
      open_slot  = 0;
      hours_held = 1;
      prev_level = COMFORT_UNKNOWN;
      mismatches = 0;
      checked    = 0;
      readings   = 0;
      ticks      = 0;
      failures   = 0;
    endfunction

    function logic [TENTHS_W-1:0] to_tenths(input logic [RAW_W-1:0] raw);
      logic [63:0] prod;
      prod = 64'(raw) * MMHG_TENTHS_K + ROUND_HALF;
      return prod[47:32];
    endfunction

    // Tests run in a fixed order, whatever the ordering of the thresholds.
    function logic [COMFORT_W-1:0] grade_spread(input logic [TENTHS_W-1:0] spread);
      if (spread < warn_th) return COMFORT_NORMAL;
      if (spread < high_th) return COMFORT_WARNING;
      if (spread < crit_th) return COMFORT_HIGH;
      return COMFORT_CRITICAL;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WARNING:  warn_th = data;
        REG_HIGH:     high_th = data;
        REG_CRITICAL: crit_th = data;
        default: ;
      endcase
    endfunction

    function void push_result(input logic [TENTHS_W-1:0] p, input logic [TENTHS_W-1:0] spread,
                              input logic [COMFORT_W-1:0] level);
      reading_result_t r;
      r.pressure = p;
      r.spread   = spread;
      r.level    = level;
      r.changed  = (level != prev_level);
      prev_level = level;
      expected_results.push_back(r);
    endfunction

    function void note_item(input logic [KIND_W-1:0] kind, input logic [RAW_W-1:0] raw);
      logic [TENTHS_W-1:0] p;
      logic [TENTHS_W-1:0] lo;
      logic [TENTHS_W-1:0] hi;
      int                  idx;
      case (kind)
        KIND_TICK: begin
          open_slot = (open_slot + 1) % RING_HOURS;
          hour_lo[open_slot] = '0;
          hour_hi[open_slot] = '0;
          if (hours_held < RING_HOURS) hours_held++;
          ticks++;
        end
        KIND_FAIL: begin
          push_result('0, '0, COMFORT_UNKNOWN);
          failures++;
        end
        KIND_READING: begin
          p = to_tenths(raw);
          // Zero marks an empty side, so any value replaces it.
          if (hour_lo[open_slot] == 0 || p < hour_lo[open_slot]) hour_lo[open_slot] = p;
          if (hour_hi[open_slot] == 0 || p > hour_hi[open_slot]) hour_hi[open_slot] = p;
          lo = hour_lo[open_slot];
          hi = hour_hi[open_slot];
          for (int k = 1; k < hours_held; k++) begin
            idx = (open_slot + RING_HOURS - k) % RING_HOURS;
            if (hour_lo[idx] != 0 && hour_lo[idx] < lo) lo = hour_lo[idx];
            if (hour_hi[idx] != 0 && hour_hi[idx] > hi) hi = hour_hi[idx];
          end
          push_result(p, hi - lo, grade_spread(hi - lo));
          readings++;
        end
        default: ;
      endcase
    endfunction

    task report(input string msg);
      if (mismatches < MAX_PRINTED) $display("ERROR %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(input logic [OUT_TDATA_W-1:0] word);
      reading_result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result %h", word));
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (word[15:0] !== want.pressure)
        report($sformatf("pressure %0d, expected %0d", word[15:0], want.pressure));
      if (word[31:16] !== want.spread)
        report($sformatf("spread %0d, expected %0d", word[31:16], want.spread));
      if (word[34:32] !== want.level)
        report($sformatf("comfort level %0d, expected %0d", word[34:32], want.level));
      if (word[35] !== want.changed)
        report($sformatf("comfort changed %b, expected %b", word[35], want.changed));
    endtask

    task flag_leftovers();
      while (expected_results.size() != 0) begin
        void'(expected_results.pop_front());
        report("expected result never arrived");
      end
    endtask

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [14:0] raw_millibar, [15] zero
  logic [IN_TUSER_W-1:0]  in_tuser;   // [1:0] kind
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [15:0] pressure_tenths, [31:16] spread_tenths, [34:32] comfort_level,
  // [35] comfort_changed
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  comfort_scoreboard sb;
  flow_mode_t        flow = FLOW_STEADY;
  int                hold_left = 0;
  int                idle_count = 0;
  int                settings = 1;

  pressure_dispersion_tracker_core #(
    .HISTORY_HOURS(RING_HOURS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int src_gap_pct();
    case (flow)
      FLOW_SRC_GAPS: return 56;
      FLOW_BOTH:     return 19;
      default:       return 0;
    endcase
  endfunction

  function automatic int sink_stall_pct();
    case (flow)
      FLOW_SINK_STALLS: return 56;
      FLOW_BOTH:        return 19;
      default:          return 0;
    endcase
  endfunction

  // The receiver; a long hold-off is counted down here while the sender keeps offering.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct());
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_item(in_tuser, in_tdata[RAW_W-1:0]);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", idle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Leaves tvalid high on return so that back-to-back items need no second assignment.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [RAW_W-1:0] raw);
    int pct;
    pct = src_gap_pct();
    if (pct > 0 && $urandom_range(99) < pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, raw};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    // A tick gives no result, but the block is not kept busy by one.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_thresholds(input logic [TENTHS_W-1:0] warn, input logic [TENTHS_W-1:0] high,
                                input logic [TENTHS_W-1:0] crit, input bit poke_unused);
    logic [CFG_IDX_W-1:0]  idx[4];
    logic [CFG_DATA_W-1:0] val[4];
    int                    n;
    idx = '{REG_WARNING, REG_HIGH, REG_CRITICAL, REG_UNUSED};
    val = '{warn, high, crit, CFG_DATA_W'($urandom)};
    n = poke_unused ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  task automatic run_directed();
    send_item(KIND_READING, 15'd0);
    send_item(KIND_READING, 15'd1);
    send_item(KIND_READING, 15'h7FFF);
    send_item(KIND_FAIL, 15'd0);
    send_item(KIND_READING, 15'd16000);
    send_item(KIND_READING, 15'd16128);
    send_item(KIND_UNUSED, 15'h7FFF);
    send_item(KIND_FAIL, 15'h7FFF);
    send_item(KIND_TICK, 15'd0);
    send_item(KIND_READING, 15'd2);
    send_item(KIND_READING, 15'h5555);
    send_item(KIND_TICK, 15'h2AAA);
    send_item(KIND_READING, 15'h2AAA);
    send_item(KIND_TICK, 15'd0);
    send_item(KIND_TICK, 15'd0);
    send_item(KIND_READING, 15'd16384);
    send_item(KIND_TICK, 15'd0);
    send_item(KIND_READING, 15'd16400);
    send_item(KIND_READING, 15'd16200);
    send_item(KIND_FAIL, 15'd0);
    send_item(KIND_READING, 15'h7FFF);
    send_item(KIND_TICK, 15'd0);
    send_item(KIND_READING, 15'd16000);
  endtask

  // Mostly readings around a drifting level, so spreads land near the thresholds.
  task automatic run_random(input int count);
    int done;
    int roll;
    int base;
    int raw;
    done = 0;
    base = $urandom_range(2000, 30000);
    while (done < count) begin
      if ($urandom_range(49) == 0) base = $urandom_range(600, 32000);
      roll = $urandom_range(99);
      if (roll < 9) begin
        send_item(KIND_TICK, RAW_W'($urandom));
      end else if (roll < 14) begin
        send_item(KIND_FAIL, RAW_W'($urandom));
      end else if (roll < 16) begin
        send_item(KIND_UNUSED, RAW_W'($urandom));
        continue;
      end else if (roll < 22) begin
        send_item(KIND_READING, RAW_W'($urandom_range(0, 32767)));
      end else if (roll < 24) begin
        send_item(KIND_READING, RAW_W'($urandom_range(0, 3)));
      end else begin
        raw = base + $urandom_range(0, 500) - 250;
        if (raw < 0) raw = 0;
        if (raw > 32767) raw = 32767;
        send_item(KIND_READING, RAW_W'(raw));
      end
      done++;
    end
  endtask

  initial begin
    logic [TENTHS_W-1:0] w;
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= KIND_READING;
    cfg_valid <= 1'b0;
    cfg_index <= REG_WARNING;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(ITEMS_PER_PHASE);
    wait_idle();

    // Every spread reads as critical.
    flow = FLOW_SRC_GAPS;
    set_thresholds('0, '0, '0, 1'b0);
    run_random(ITEMS_PER_PHASE);
    wait_idle();

    flow = FLOW_SINK_STALLS;
    set_thresholds(TH_MAX, TH_MAX, TH_MAX, 1'b1);
    run_random(ITEMS_PER_PHASE);
    wait_idle();

    // Descending thresholds: the fixed order of tests decides.
    flow = FLOW_BOTH;
    set_thresholds(16'd100, 16'd50, 16'd20, 1'b0);
    run_random(ITEMS_PER_PHASE);
    wait_idle();

    flow = FLOW_STEADY;
    w = TENTHS_W'($urandom_range(20, 120));
    set_thresholds(w, w + TENTHS_W'($urandom_range(0, 60)),
                   w + TENTHS_W'($urandom_range(60, 150)), 1'b0);
    hold_left = PRESSURE_HOLD;
    run_random(ITEMS_PER_PHASE);
    wait_idle();

    flow = FLOW_BOTH;
    set_thresholds(TENTHS_W'($urandom), TENTHS_W'($urandom), TENTHS_W'($urandom), 1'b1);
    run_random(ITEMS_PER_PHASE);
    wait_idle();

    sb.flag_leftovers();
    $display("Run covered %0d readings, %0d hour ticks and %0d sensor failures under %0d %s",
             sb.readings, sb.ticks, sb.failures, settings, "threshold settings.");
    $display("%0d results compared, %0d mismatches found.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- pressure_dispersion_tracker_core.f -----
design/pdt_pkg.sv
design/pdt_ram.sv
design/pressure_dispersion_tracker_core.sv
bench/tb_pressure_dispersion_tracker_core.sv
